// ----- design/grid_trilinear_interpolator_unit_defines.svh -----
// Assertion macros shared by the grid interpolator RTL.
// Depends on nothing; included by the modules that assert.
`ifndef GRID_TRILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define GRID_TRILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next cycle.
`define GTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Assert that a condition holds at every clock edge outside reset.
`define GTI_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ----- design/gti_pkg.sv -----
// Package for the grid interpolator: payload types, constants, state enums.
// Depends on nothing.
`default_nettype none
package gti_pkg;
    localparam int STORE_DEPTH = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int REG_W       = 64;
    localparam int IDX_W       = 3;
    localparam int PTS_W       = 9;

    localparam logic [IDX_W-1:0] REG_X_BOUNDS = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_BOUNDS = 3'd1;
    localparam logic [IDX_W-1:0] REG_Z_BOUNDS = 3'd2;
    localparam logic [IDX_W-1:0] REG_POINTS_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_POINTS_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_POINTS_Z = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               status;
    } t_rsp;

    // Divider request/response between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
        logic [32:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_AXIS, S_DIVC, S_WAITC, S_DIVF, S_WAITF,
        S_RD, S_RDW, S_BLEND, S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- design/gti_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on gti_pkg.
`default_nettype none
module gti_divider
    import gti_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int NW = 48;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [33:0]   r_rem, n_rem;
    logic [32:0]   r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [33:0]   shifted;
    logic [34:0]   diff;

    always_comb begin
        shifted = {r_rem[32:0], r_quo[NW-1]};
        diff    = {1'b0, shifted} - {2'b0, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[34]) begin
                n_rem = diff[33:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[32:0];
endmodule
`default_nettype wire

// ----- design/grid_trilinear_interpolator_unit.sv -----
// Top level of the grid trilinear interpolator: grid store, sequencer, blend unit.
// Depends on gti_pkg, gti_divider and the defines header.
`default_nettype none
`include "grid_trilinear_interpolator_unit_defines.svh"
// A write request (opcode 0) stores one sample in the grid memory while busy is high;
// no result follows. A query request (opcode 1) on an oversized grid goes straight to
// S_DONE with the error status. Otherwise each axis with a nonempty span runs two
// passes of a shared 48-step bit-serial divider (cell index, then fraction), each
// started in S_DIVC or S_DIVF and waited out in S_WAITC or S_WAITF, after the S_AXIS
// setup state; an axis with an empty span only passes through S_AXIS. Then the four
// (2D mode) or eight (3D mode) corners are read in turn from the single memory port,
// each in an S_RD and an S_RDW state, and the three or seven blends run one per cycle
// on one shared multiplier. o_valid pulses for one cycle with o_rsp in the first cycle
// that busy is low, so the next request can be accepted at the end of that cycle; the
// receiver cannot stall it. Configuration must be written only while busy is low.
module grid_trilinear_interpolator_unit
    import gti_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_valid,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data
);
    logic [REG_W-1:0] r_bnd [3];
    logic [PTS_W-1:0] r_pts [3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd[0] <= 64'h0001_0000_0000_0000;
            r_bnd[1] <= 64'h0001_0000_0000_0000;
            r_bnd[2] <= 64'h0001_0000_0000_0000;
            r_pts[0] <= 9'd2;
            r_pts[1] <= 9'd2;
            r_pts[2] <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_BOUNDS: r_bnd[0] <= i_cfg_data;
                REG_Y_BOUNDS: r_bnd[1] <= i_cfg_data;
                REG_Z_BOUNDS: r_bnd[2] <= i_cfg_data;
                REG_POINTS_X: r_pts[0] <= i_cfg_data[PTS_W-1:0];
                REG_POINTS_Y: r_pts[1] <= i_cfg_data[PTS_W-1:0];
                REG_POINTS_Z: r_pts[2] <= i_cfg_data[PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective point counts
    logic [PTS_W-1:0] nx, ny, nz;
    assign nx = (r_pts[0] < 9'd2) ? 9'd2 : r_pts[0];
    assign ny = (r_pts[1] < 9'd2) ? 9'd2 : r_pts[1];
    assign nz = (r_pts[2] == 9'd0) ? 9'd1 : r_pts[2];
    logic two_d;
    assign two_d = (nz == 9'd1);

    // grid larger than the store: answer at once with the error status
    logic big;
    assign big = (32'(nx) * 32'(ny) * 32'(nz)) > 32'(STORE_DEPTH);

    // grid memory
    logic [31:0]       mem [STORE_DEPTH];
    logic [31:0]       r_rdata;

    t_state r_st, n_st;
    t_req   r_q;
    logic [1:0]  r_ax, n_ax;
    logic [2:0]  r_cnt, n_cnt;
    logic [8:0]  r_cell [3];
    logic [16:0] r_frac [3];
    logic signed [31:0] r_v [8];
    logic [32:0] r_span;
    logic [32:0] r_off;
    logic [9:0]  r_nn;
    logic [31:0] r_lin;
    logic        r_big;
    logic        r_oval;
    t_rsp        r_orsp;

    t_div_req dreq;
    t_div_rsp drsp;

    gti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_rsp   (drsp)
    );

    // per-axis bounds of the current axis
    logic signed [31:0] lo, hi, p;
    logic signed [32:0] pc;
    always_comb begin
        lo = r_bnd[r_ax][31:0];
        hi = r_bnd[r_ax][63:32];
        unique case (r_ax)
            2'd0:    p = r_q.point_x;
            2'd1:    p = r_q.point_y;
            default: p = r_q.point_z;
        endcase
        pc = (p < lo) ? 33'(lo) : (p > hi) ? 33'(hi) : 33'(p);
    end

    logic [PTS_W-1:0] n_axis;
    assign n_axis = r_pts[r_ax] < 9'd2 ? (r_ax == 2'd2 ? nz : 9'd2) : r_pts[r_ax];

    // corner address: bit0 = x+1, bit1 = y+1, bit2 = z+1
    logic [31:0] caddr;
    always_comb begin
        caddr = 32'(r_cell[0]) + 32'(r_cnt[0])
              + (32'(r_cell[1]) + 32'(r_cnt[1])) * 32'(nx)
              + (32'(r_cell[2]) + 32'(r_cnt[2])) * r_lin;
    end

    // shared blend: a + round((b-a)*t)
    logic signed [31:0] ba, bb;
    logic [16:0]        bt;
    logic signed [32:0] bd;
    logic signed [50:0] bprod;
    logic signed [31:0] bres;
    always_comb begin
        bd    = 33'(bb) - 33'(ba);
        bprod = 51'(bd) * $signed({34'd0, bt});
        bres  = 32'(ba + 32'((bprod + 51'sd32768) >>> FRAC_BITS));
    end

    // blend schedule: pair index and fraction per step
    logic [2:0] bsel_a, bsel_b, bdst;
    logic [1:0] bax;
    always_comb begin
        case (r_cnt)
            3'd0: begin bsel_a = 3'd0; bsel_b = 3'd1; bdst = 3'd0; bax = 2'd0; end
            3'd1: begin bsel_a = 3'd2; bsel_b = 3'd3; bdst = 3'd2; bax = 2'd0; end
            3'd2: begin bsel_a = 3'd4; bsel_b = 3'd5; bdst = 3'd4; bax = 2'd0; end
            3'd3: begin bsel_a = 3'd6; bsel_b = 3'd7; bdst = 3'd6; bax = 2'd0; end
            3'd4: begin bsel_a = 3'd0; bsel_b = 3'd2; bdst = 3'd0; bax = 2'd1; end
            3'd5: begin bsel_a = 3'd4; bsel_b = 3'd6; bdst = 3'd4; bax = 2'd1; end
            default: begin bsel_a = 3'd0; bsel_b = 3'd4; bdst = 3'd0; bax = 2'd2; end
        endcase
        ba = r_v[bsel_a];
        bb = r_v[bsel_b];
        bt = r_frac[bax];
    end

    logic [2:0] last_corner;
    assign last_corner = two_d ? 3'd3 : 3'd7;

    // sequencer
    always_comb begin
        n_st  = r_st;
        n_ax  = r_ax;
        n_cnt = r_cnt;
        dreq  = '0;
        unique case (r_st)
            S_IDLE: if (start) n_st = S_CHECK;
            S_CHECK: begin
                // a write request just lands in memory
                if (r_q.opcode == OP_WRITE) n_st = S_IDLE;
                else if (big) n_st = S_DONE;
                else begin
                    n_ax = 2'd0;
                    n_st = S_AXIS;
                end
            end
            S_AXIS: begin
                if (hi <= lo) n_st = S_RD;
                else n_st = S_DIVC;
                if (hi <= lo) begin
                    if (r_ax == 2'd0 || (r_ax == 2'd1 && !two_d)) begin
                        n_ax = r_ax + 2'd1;
                        n_st = S_AXIS;
                    end else n_cnt = 3'd0;
                end
            end
            S_DIVC: begin
                dreq.start = 1'b1;
                dreq.num   = 48'(r_off) * 48'(r_nn);
                dreq.den   = r_span;
                n_st = S_WAITC;
            end
            S_WAITC: if (drsp.done) n_st = S_DIVF;
            S_DIVF: begin
                dreq.start = 1'b1;
                dreq.num   = {drsp.rem[31:0], 16'd0};
                dreq.den   = r_span;
                n_st = S_WAITF;
            end
            S_WAITF: begin
                if (drsp.done) begin
                    if (r_ax == 2'd0 || (r_ax == 2'd1 && !two_d)) begin
                        n_ax = r_ax + 2'd1;
                        n_st = S_AXIS;
                    end else begin
                        n_cnt = 3'd0;
                        n_st  = S_RD;
                    end
                end
            end
            S_RD: n_st = S_RDW;
            S_RDW: begin
                if (r_cnt == last_corner) begin
                    n_cnt = 3'd0;
                    n_st  = S_BLEND;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                    n_st  = S_RD;
                end
            end
            S_BLEND: begin
                if (two_d && r_cnt == 3'd4) begin
                    n_st = S_DONE;
                end else if (r_cnt == 3'd6) n_st = S_DONE;
                else if (two_d && r_cnt == 3'd1) n_cnt = 3'd4;
                else n_cnt = r_cnt + 3'd1;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    logic [2:0] rd_slot;
    assign rd_slot = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ax   <= 2'd0;
            r_cnt  <= 3'd0;
            r_oval <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_ax   <= n_ax;
            r_cnt  <= n_cnt;
            r_oval <= (r_st == S_DONE);
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && start) r_q <= i_req;
        if (r_st == S_CHECK) begin
            r_big <= big;
            r_lin <= 32'(nx) * 32'(ny);
            if (r_q.opcode == OP_WRITE && 32'(r_q.entry_index) < 32'(STORE_DEPTH))
                mem[ADDR_W'(r_q.entry_index)] <= r_q.entry_value;
        end
        if (r_st == S_AXIS) begin
            r_off  <= 33'(pc - 33'(lo));
            r_span <= 33'(33'(hi) - 33'(lo));
            r_nn   <= 10'(n_axis) - 10'd1;
            r_cell[r_ax] <= 9'd0;
            r_frac[r_ax] <= 17'd0;
            if (two_d) begin
                r_cell[2] <= 9'd0;
                r_frac[2] <= 17'd0;
            end
        end
        if (r_st == S_WAITC && drsp.done) begin
            if (drsp.quo > 48'(r_nn - 10'd1)) begin
                r_cell[r_ax] <= 9'(r_nn - 10'd1);
                r_frac[r_ax] <= 17'h10000;
            end else begin
                r_cell[r_ax] <= 9'(drsp.quo);
            end
        end
        if (r_st == S_WAITF && drsp.done && r_frac[r_ax] != 17'h10000)
            r_frac[r_ax] <= 17'(drsp.quo);
        // registered read: the corner word is ready in the following S_RDW cycle
        if (r_st == S_RD) r_rdata <= mem[ADDR_W'(caddr)];
        if (r_st == S_RDW) r_v[rd_slot] <= r_rdata;
        if (r_st == S_BLEND) r_v[bdst] <= bres;
        if (r_st == S_DONE) begin
            r_orsp.interp_value <= r_big ? 32'sd0 : r_v[0];
            r_orsp.status       <= r_big;
        end
    end

    assign busy    = (r_st != S_IDLE);
    assign o_valid = r_oval;
    assign o_rsp   = r_orsp;

    `GTI_ASSERT_NEXT(a_busy_on_start, i_clk, i_rst_n, start && !busy, busy)
    `GTI_ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_st == S_DONE, o_valid && !busy)
    `GTI_ASSERT_ALWAYS(a_no_div_while_idle, i_clk, i_rst_n, !(dreq.start && r_st == S_IDLE))
endmodule
`default_nettype wire
